@@ design/fra_pkg.sv @@
// Shared types, constants and a helper function for the fragment reassembler.
`default_nettype none
package fra_pkg;

  localparam int MAX_FRAGMENTS_DEF = 16;
  localparam int CHUNK_BYTES = 16;
  localparam int LEN_W = 5;
  localparam int DATA_W = 64;
  localparam int POS_W = 8;
  localparam logic [LEN_W-1:0] LEN_FIELD_MASK = 5'h1f;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } chunk_t;

  typedef struct packed {
    logic             valid;
    logic             status;
    logic [POS_W-1:0] position;
    logic             last;
  } load_t;

  localparam logic STATUS_CHUNK = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Clamps the length field and zeroes every byte past the length.
  function automatic chunk_t make_chunk(logic [7:0] flags, logic [DATA_W-1:0] lo,
                                        logic [DATA_W-1:0] hi);
    chunk_t c;
    logic [LEN_W-1:0] len;
    len = flags[LEN_W-1:0] & LEN_FIELD_MASK;
    if (len > LEN_W'(CHUNK_BYTES)) begin
      len = LEN_W'(CHUNK_BYTES);
    end
    c.len = len;
    for (int b = 0; b < 8; b++) begin
      c.lo[8*b +: 8] = (LEN_W'(b) < len) ? lo[8*b +: 8] : 8'h00;
      c.hi[8*b +: 8] = (LEN_W'(b + 8) < len) ? hi[8*b +: 8] : 8'h00;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/fra_store.sv @@
// Chunk store: one-write, one-read memory with a registered read port.
`default_nettype none
module fra_store
  import fra_pkg::*;
#(
  parameter int DEPTH = MAX_FRAGMENTS_DEF,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire chunk_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output chunk_t                rd_data
);

  chunk_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ design/fra_ctrl.sv @@
// Reassembly control: presence mask, fragment count, completion and drain sequencing.
`default_nettype none
module fra_ctrl
  import fra_pkg::*;
#(
  parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF,
  parameter int IDX_W = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        frag_index,
  input  wire logic [7:0]        frag_total,
  input  wire logic [7:0]        frag_flags,
  input  wire logic [DATA_W-1:0] payload_low,
  input  wire logic [DATA_W-1:0] payload_high,
  input  wire logic              out_free,
  output logic                   wr_en,
  output logic [IDX_W-1:0]       wr_addr,
  output chunk_t                 wr_data,
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  output load_t                  ld
);

  localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                   state, state_next;
  logic                     total_known;
  logic [7:0]               expected_total;
  logic [CNT_W-1:0]         received_count;
  logic [MAX_FRAGMENTS-1:0] present_mask;
  logic [MAX_FRAGMENTS-1:0] drain_mask;
  logic                     rd_pending;
  logic [POS_W-1:0]         rd_pos;
  logic                     rd_last;

  logic                     in_accept;
  logic                     out_of_range;
  logic                     is_dup;
  logic                     err_load;
  logic                     move;
  logic                     cmpl;
  logic [7:0]               eff_total;
  logic [CNT_W-1:0]         count_inc;
  logic [MAX_FRAGMENTS-1:0] new_bit;
  logic [MAX_FRAGMENTS-1:0] lowest;
  logic [MAX_FRAGMENTS-1:0] rest;
  logic [IDX_W-1:0]         first;

  assign in_ready     = (state == ST_IDLE) && !rd_pending && out_free;
  assign in_accept    = in_valid && in_ready;
  assign out_of_range = frag_index >= 8'(MAX_FRAGMENTS);
  assign wr_addr      = frag_index[IDX_W-1:0];
  assign new_bit      = MAX_FRAGMENTS'(1) << wr_addr;
  assign is_dup       = |(present_mask & new_bit);
  assign wr_en        = in_accept && !out_of_range && !is_dup;
  assign wr_data      = make_chunk(frag_flags, payload_low, payload_high);
  assign err_load     = in_accept && out_of_range;
  assign eff_total    = total_known ? expected_total : frag_total;
  assign count_inc    = received_count + CNT_W'(1);
  assign cmpl         = wr_en && (8'(count_inc) == eff_total);

  assign lowest = drain_mask & (~drain_mask + MAX_FRAGMENTS'(1));
  assign rest   = drain_mask & ~lowest;

  always_comb begin
    first = '0;
    for (int i = 0; i < MAX_FRAGMENTS; i++) begin
      first = first | (lowest[i] ? IDX_W'(i) : IDX_W'(0));
    end
  end

  assign move    = rd_pending && out_free;
  assign rd_en   = (state == ST_DRAIN) && (!rd_pending || out_free);
  assign rd_addr = first;

  always_comb begin
    ld.valid    = move || err_load;
    ld.status   = err_load ? STATUS_RANGE : STATUS_CHUNK;
    ld.position = err_load ? frag_index : rd_pos;
    ld.last     = err_load ? 1'b1 : rd_last;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmpl) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (rd_en && (rest == '0)) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      total_known    <= 1'b0;
      expected_total <= '0;
      received_count <= '0;
      present_mask   <= '0;
      drain_mask     <= '0;
      rd_pending     <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_en || (rd_pending && !move);
      if (cmpl) begin
        total_known    <= 1'b0;
        expected_total <= '0;
        received_count <= '0;
        present_mask   <= '0;
        drain_mask     <= present_mask | new_bit;
      end else begin
        if (in_accept && !total_known) begin
          total_known    <= 1'b1;
          expected_total <= frag_total;
        end
        if (wr_en) begin
          received_count <= count_inc;
          present_mask   <= present_mask | new_bit;
        end
        if (rd_en) begin
          drain_mask <= rest;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pos  <= POS_W'(first);
      rd_last <= (rest == '0);
    end
  end

  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(err_load && move))
    else $error("range error and drained chunk loaded together");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !in_ready)
    else $error("input accepted during drain");

  a_read_present: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> drain_mask[rd_addr])
    else $error("read of an entry not in the drain set");

  a_cmpl_clears: assert property (@(posedge clk) disable iff (rst)
    cmpl |=> (present_mask == '0) && (state == ST_DRAIN) && !total_known)
    else $error("store not cleared after completion");

endmodule
`default_nettype wire

@@ design/fra_out.sv @@
// Output register holding one result word until the consumer takes it.
`default_nettype none
module fra_out
  import fra_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire load_t        ld,
  input  wire chunk_t       rd_data,
  output logic              out_free,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              status,
  output logic [POS_W-1:0]  chunk_position,
  output logic [LEN_W-1:0]  chunk_bytes,
  output logic [DATA_W-1:0] chunk_low,
  output logic [DATA_W-1:0] chunk_high,
  output logic              last
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.valid) begin
      status         <= ld.status;
      chunk_position <= ld.position;
      last           <= ld.last;
      if (ld.status == STATUS_RANGE) begin
        chunk_bytes <= '0;
        chunk_low   <= '0;
        chunk_high  <= '0;
      end else begin
        chunk_bytes <= rd_data.len;
        chunk_low   <= rd_data.lo;
        chunk_high  <= rd_data.hi;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/fragment_reassembler.sv @@
// Fragment reassembler top level: control, chunk store and output register.
// A range error appears in the cycle after its fragment. On completion the store
// drains one chunk per cycle while the output register is free; the first chunk passes
// the drain state, the store read port and the output register in that order. No
// fragment is taken during a drain. Reset clears the control state and the presence
// mask; the chunk store itself is not cleared and needs no clearing pass.
`default_nettype none
module fragment_reassembler
  import fra_pkg::*;
#(
  parameter int MAX_FRAGMENTS = MAX_FRAGMENTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        frag_index,
  input  wire logic [7:0]        frag_total,
  input  wire logic [7:0]        frag_flags,
  input  wire logic [DATA_W-1:0] payload_low,
  input  wire logic [DATA_W-1:0] payload_high,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   status,
  output logic [POS_W-1:0]       chunk_position,
  output logic [LEN_W-1:0]       chunk_bytes,
  output logic [DATA_W-1:0]      chunk_low,
  output logic [DATA_W-1:0]      chunk_high,
  output logic                   last
);

  localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

  logic             out_free;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  chunk_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  chunk_t           rd_data;
  load_t            ld;

  fra_ctrl #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS),
    .IDX_W(IDX_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frag_index(frag_index),
    .frag_total(frag_total),
    .frag_flags(frag_flags),
    .payload_low(payload_low),
    .payload_high(payload_high),
    .out_free(out_free),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .ld(ld)
  );

  fra_store #(
    .DEPTH(MAX_FRAGMENTS),
    .IDX_W(IDX_W)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  fra_out u_out (
    .clk(clk),
    .rst(rst),
    .ld(ld),
    .rd_data(rd_data),
    .out_free(out_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .chunk_position(chunk_position),
    .chunk_bytes(chunk_bytes),
    .chunk_low(chunk_low),
    .chunk_high(chunk_high),
    .last(last)
  );

endmodule
`default_nettype wire
